// ===== hdl/ptpg_pkg.sv =====
// ----------------------------------------------------------------------------
// ptpg_pkg: shared types and constants for the pulse table PWM generator
// Item and result payloads, mode codes, controller states and the
// command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package ptpg_pkg;

  // Default geometry
  localparam int TABLE_DEPTH_DEF = 2048;
  localparam int PIN_COUNT_DEF   = 32;

  // Fixed field widths
  localparam int MODE_W  = 3;
  localparam int PIN_W   = 5;
  localparam int START_W = 11;
  localparam int WIDTH_W = 12;
  localparam int LEVEL_W = 32;
  localparam int POS_W   = 11;
  localparam int CFG_W   = 12;

  // Mode codes
  localparam logic [MODE_W-1:0] MODE_TICK    = 3'd0;
  localparam logic [MODE_W-1:0] MODE_ADD     = 3'd1;
  localparam logic [MODE_W-1:0] MODE_SET     = 3'd2;
  localparam logic [MODE_W-1:0] MODE_CLR_PIN = 3'd3;
  localparam logic [MODE_W-1:0] MODE_CLR_ALL = 3'd4;

  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic [PIN_W-1:0]   pin;
    logic [START_W-1:0] start_req;
    logic [WIDTH_W-1:0] width;
  } item_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] pin_levels;
    logic [POS_W-1:0]   position;
  } result_t;

  // What an incoming item asks of the sequencer
  typedef enum logic [1:0] {
    KIND_NONE,
    KIND_TICK,
    KIND_PULSE,
    KIND_SWEEP
  } kind_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MOD,
    ST_WALK,
    ST_POST_RD,
    ST_POST_WR,
    ST_TICK_RD,
    ST_TICK_AP,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic clr_run;
    logic load;
    logic walk_init;
    logic walk_run;
    logic post_rd;
    logic post_wr;
    logic tick_rd;
    logic tick_apply;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    kind_t kind;
    logic  clr_last;
    logic  mod_done;
    logic  walk_done;
    logic  post_need;
    logic  out_free;
  } sts_t;

endpackage

// ===== hdl/ptpg_rem.sv =====
// ----------------------------------------------------------------------------
// ptpg_rem: sequential remainder unit
// Restoring shift-subtract, one dividend bit per cycle; reduces the pulse
// start slot modulo the number of slots in use.
// ----------------------------------------------------------------------------
module ptpg_rem #(
  parameter int TABLE_DEPTH = ptpg_pkg::TABLE_DEPTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  input  logic [ptpg_pkg::START_W-1:0]         dividend,
  input  logic [$clog2(TABLE_DEPTH+1)-1:0]     divisor,
  output logic                                 done,
  output logic [$clog2(TABLE_DEPTH)-1:0]       remainder
);
  import ptpg_pkg::*;

  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int CW    = $clog2(START_W + 1);

  logic [CW-1:0]      cnt;
  logic [START_W-1:0] dvd;
  logic [IDX_W-1:0]   acc;
  logic [IDX_W:0]     trial;
  logic [IDX_W:0]     dsr;

  // trial = 2*acc + next dividend bit, always below twice the divisor
  assign trial = {acc, dvd[START_W-1]};
  assign dsr   = (IDX_W+1)'(divisor);

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= CW'(START_W);
    end else if (cnt != '0) begin
      cnt <= cnt - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      acc <= '0;
    end else if (cnt != '0) begin
      dvd <= {dvd[START_W-2:0], 1'b0};
      acc <= (trial >= dsr) ? IDX_W'(trial - dsr) : IDX_W'(trial);
    end
  end

  assign done      = (cnt == '0);
  assign remainder = acc;

endmodule

// ===== hdl/ptpg_datapath.sv =====
// ----------------------------------------------------------------------------
// ptpg_datapath: slot table, pin levels, cursor and edit walker
// Holds the slot memory (mask plus set flag per slot), one read and one
// write per cycle, a one-stage read-modify-write pipe for table walks,
// and the result register.
// ----------------------------------------------------------------------------
module ptpg_datapath #(
  parameter int TABLE_DEPTH = ptpg_pkg::TABLE_DEPTH_DEF,
  parameter int PIN_COUNT   = ptpg_pkg::PIN_COUNT_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  ptpg_pkg::item_t              item,
  input  logic                         cfg_wen,
  input  logic [ptpg_pkg::CFG_W-1:0]   cfg_wdata,
  input  ptpg_pkg::cmd_t               cmd,
  output ptpg_pkg::sts_t               sts,
  output logic                         result_valid,
  input  logic                         result_stall,
  output ptpg_pkg::result_t            result
);
  import ptpg_pkg::*;

  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int MW    = PIN_COUNT;

  // Slot memory: bit MW is the set flag, bits below are the pin mask
  logic [MW:0]        mem [TABLE_DEPTH];
  logic [MW:0]        rdata;
  logic               we;
  logic [IDX_W-1:0]   waddr;
  logic [IDX_W-1:0]   raddr;
  logic [MW:0]        wdata;

  logic [CNT_W-1:0]   n;
  logic [CNT_W-1:0]   n_cfg;
  logic [IDX_W-1:0]   cursor;
  logic [MW-1:0]      levels;
  logic [MW-1:0]      levels_next;
  logic [MW-1:0]      ready_pins;
  logic [MW-1:0]      ready_pins_next;
  logic [IDX_W-1:0]   clr_ptr;

  // Latched edit
  logic [MODE_W-1:0]  op_mode;
  logic [MW-1:0]      op_bit;
  logic [CNT_W-1:0]   op_w;
  logic [CNT_W-1:0]   op_len;

  // Walker
  logic [IDX_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   issued;
  logic               issue;
  logic               s1_valid;
  logic [IDX_W-1:0]   s1_ptr;
  logic [IDX_W-1:0]   s1_off;
  logic               seen_set;
  logic               seen_next;
  logic [MW-1:0]      wr_mask;
  logic               wr_set;

  // Incoming item decode
  logic               pin_ok;
  logic [MW-1:0]      in_bit;
  logic [CNT_W-1:0]   w_cl;
  logic [CNT_W-1:0]   in_len;
  kind_t              in_kind;

  logic               rem_done;
  logic [IDX_W-1:0]   rem_val;

  function automatic logic [IDX_W-1:0] step_slot(input logic [IDX_W-1:0] p,
                                                  input logic [CNT_W-1:0] lim);
    logic [CNT_W:0] q;
    q = (CNT_W+1)'(p) + (CNT_W+1)'(1);
    return (q >= (CNT_W+1)'(lim)) ? '0 : IDX_W'(q);
  endfunction

  // Start slot modulo slots in use
  ptpg_rem #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_rem (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.load),
    .dividend (item.start_req),
    .divisor  (n),
    .done     (rem_done),
    .remainder(rem_val)
  );

  // Register value clamped into 1..TABLE_DEPTH
  always_comb begin
    if (cfg_wdata == '0) begin
      n_cfg = CNT_W'(1);
    end else if (32'(cfg_wdata) > 32'(TABLE_DEPTH)) begin
      n_cfg = CNT_W'(TABLE_DEPTH);
    end else begin
      n_cfg = CNT_W'(cfg_wdata);
    end
  end

  // Item decode
  always_comb begin
    pin_ok = 32'(item.pin) < 32'(PIN_COUNT);
    for (int k = 0; k < MW; k++) begin
      in_bit[k] = (item.pin == PIN_W'(k));
    end
    w_cl   = (32'(item.width) > 32'(n)) ? n : CNT_W'(item.width);
    in_len = (item.mode == MODE_ADD) ? w_cl : n;
    case (item.mode)
      MODE_TICK:              in_kind = KIND_TICK;
      MODE_ADD, MODE_SET:     in_kind = pin_ok ? KIND_PULSE : KIND_NONE;
      MODE_CLR_PIN:           in_kind = pin_ok ? KIND_SWEEP : KIND_NONE;
      MODE_CLR_ALL:           in_kind = KIND_SWEEP;
      default:                in_kind = KIND_NONE;
    endcase
  end

  // Slot rewrite for the walk stage
  always_comb begin
    logic [CNT_W-1:0] off;
    logic             hit;
    off       = CNT_W'(s1_off);
    hit       = |(rdata[MW-1:0] & op_bit);
    wr_mask   = rdata[MW-1:0];
    wr_set    = rdata[MW];
    seen_next = seen_set;
    case (op_mode)
      MODE_ADD: begin
        if (off == '0) begin
          wr_mask = rdata[MW-1:0] | op_bit;
          wr_set  = 1'b1;
        end else begin
          if (hit) seen_next = rdata[MW];
          wr_mask = rdata[MW-1:0] & ~op_bit;
        end
      end
      MODE_SET: begin
        if (off == '0 && op_w != '0) begin
          wr_mask = rdata[MW-1:0] | op_bit;
          wr_set  = 1'b1;
        end else if (off == op_w && op_w != '0) begin
          wr_mask = rdata[MW-1:0] | op_bit;
          wr_set  = 1'b0;
        end else if (off > op_w) begin
          if (hit) wr_set = 1'b0;
        end else begin
          wr_mask = rdata[MW-1:0] & ~op_bit;
        end
      end
      MODE_CLR_PIN: begin
        wr_mask = rdata[MW-1:0] & ~op_bit;
      end
      MODE_CLR_ALL: begin
        wr_mask = '0;
        wr_set  = 1'b0;
      end
      default: begin
      end
    endcase
  end

  // Memory port selection
  always_comb begin
    we    = 1'b0;
    waddr = rd_ptr;
    wdata = {wr_set, wr_mask};
    if (cmd.clr_run) begin
      we    = 1'b1;
      waddr = clr_ptr;
      wdata = '0;
    end else if (s1_valid) begin
      we    = 1'b1;
      waddr = s1_ptr;
    end else if (cmd.post_wr) begin
      we    = 1'b1;
      wdata = {1'b0, rdata[MW-1:0] | op_bit};
    end
    raddr = cmd.tick_rd ? cursor : rd_ptr;
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

  // Clearing pass pointer
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_ptr <= '0;
    end else if (cmd.clr_run) begin
      clr_ptr <= clr_ptr + IDX_W'(1);
    end
  end

  // Edit latch and walker
  assign issue = cmd.walk_run && (issued != op_len);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_mode <= item.mode;
      op_bit  <= in_bit;
      op_w    <= w_cl;
      op_len  <= in_len;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr   <= '0;
      issued   <= '0;
      s1_valid <= 1'b0;
      seen_set <= 1'b0;
    end else begin
      s1_valid <= issue;
      if (cmd.load) begin
        rd_ptr   <= '0;
        issued   <= '0;
        seen_set <= 1'b0;
      end else if (cmd.walk_init) begin
        rd_ptr <= rem_val;
      end else if (issue) begin
        rd_ptr <= step_slot(rd_ptr, n);
        issued <= issued + CNT_W'(1);
      end
      if (s1_valid) seen_set <= seen_next;
    end
  end

  always_ff @(posedge clk) begin
    s1_ptr <= rd_ptr;
    s1_off <= IDX_W'(issued);
  end

  // Pin levels and first-use tracking
  always_comb begin
    levels_next     = levels;
    ready_pins_next = ready_pins;
    if (cmd.load && pin_ok) begin
      case (item.mode)
        MODE_ADD: begin
          levels_next     = levels & ~(in_bit & ~ready_pins);
          ready_pins_next = ready_pins | in_bit;
        end
        MODE_SET: begin
          levels_next     = levels & ~(in_bit & ~ready_pins);
          ready_pins_next = ready_pins | in_bit;
          if (w_cl == '0) levels_next = levels & ~in_bit;
        end
        MODE_CLR_PIN: begin
          levels_next = levels & ~in_bit;
        end
        default: begin
        end
      endcase
    end
    if (s1_valid && op_mode == MODE_CLR_ALL) begin
      levels_next = levels & ~rdata[MW-1:0];
    end
    if (cmd.tick_apply) begin
      levels_next = rdata[MW] ? (levels | rdata[MW-1:0]) : (levels & ~rdata[MW-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      levels     <= '0;
      ready_pins <= '0;
      n          <= CNT_W'(TABLE_DEPTH);
      cursor     <= '0;
    end else begin
      levels     <= levels_next;
      ready_pins <= ready_pins_next;
      if (cfg_wen) begin
        n <= n_cfg;
        if (32'(cursor) >= 32'(n_cfg)) cursor <= '0;
      end else if (cmd.tick_apply) begin
        cursor <= step_slot(cursor, n);
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.out_load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      result.pin_levels <= LEVEL_W'(levels);
      result.position   <= POS_W'(cursor);
    end
  end

  // Status to the controller
  always_comb begin
    sts.kind      = in_kind;
    sts.clr_last  = (clr_ptr == IDX_W'(TABLE_DEPTH - 1));
    sts.mod_done  = rem_done;
    sts.walk_done = (issued == op_len) && !s1_valid;
    sts.post_need = (op_mode == MODE_ADD) && (op_w < n) && !seen_set;
    sts.out_free  = !result_valid || !result_stall;
  end

  // Checks
  a_cursor_range: assert property (@(posedge clk) disable iff (rst)
    32'(cursor) < 32'(n))
    else $error("cursor beyond slots in use");

  a_walk_range: assert property (@(posedge clk) disable iff (rst)
    s1_valid |-> 32'(s1_ptr) < 32'(n))
    else $error("walk slot beyond slots in use");

  a_walk_count: assert property (@(posedge clk) disable iff (rst)
    cmd.walk_run |-> 32'(issued) <= 32'(op_len))
    else $error("walk issued past its length");

  a_out_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!result_valid || !result_stall))
    else $error("result overwritten while stalled");

endmodule

// ===== hdl/ptpg_ctrl.sv =====
// ----------------------------------------------------------------------------
// ptpg_ctrl: sequencer for the pulse table PWM generator
// Runs the clearing pass after reset, then steps each accepted item
// through start reduction, table walk, trailing slot write or tick apply.
// ----------------------------------------------------------------------------
module ptpg_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            item_valid,
  output logic            item_stall,
  input  ptpg_pkg::sts_t  sts,
  output ptpg_pkg::cmd_t  cmd
);
  import ptpg_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR:   if (sts.clr_last) state_next = ST_IDLE;
      ST_IDLE: begin
        if (item_valid) begin
          case (sts.kind)
            KIND_TICK:  state_next = ST_TICK_RD;
            KIND_PULSE: state_next = ST_MOD;
            KIND_SWEEP: state_next = ST_WALK;
            default:    state_next = ST_DONE;
          endcase
        end
      end
      ST_MOD:     if (sts.mod_done) state_next = ST_WALK;
      ST_WALK: begin
        if (sts.walk_done) state_next = sts.post_need ? ST_POST_RD : ST_DONE;
      end
      ST_POST_RD: state_next = ST_POST_WR;
      ST_POST_WR: state_next = ST_DONE;
      ST_TICK_RD: state_next = ST_TICK_AP;
      ST_TICK_AP: state_next = ST_DONE;
      ST_DONE:    if (sts.out_free) state_next = ST_IDLE;
      default:    state_next = ST_CLEAR;
    endcase
  end

  // Commands
  always_comb begin
    cmd            = '0;
    item_stall     = 1'b1;
    case (state)
      ST_CLEAR:   cmd.clr_run = 1'b1;
      ST_IDLE: begin
        item_stall = 1'b0;
        cmd.load   = item_valid;
      end
      ST_MOD:     cmd.walk_init  = sts.mod_done;
      ST_WALK:    cmd.walk_run   = 1'b1;
      ST_POST_RD: cmd.post_rd    = 1'b1;
      ST_POST_WR: cmd.post_wr    = 1'b1;
      ST_TICK_RD: cmd.tick_rd    = 1'b1;
      ST_TICK_AP: cmd.tick_apply = 1'b1;
      ST_DONE:    cmd.out_load   = sts.out_free;
      default: begin
      end
    endcase
  end

endmodule

// ===== hdl/pulse_table_pwm_generator.sv =====
// ----------------------------------------------------------------------------
// pulse_table_pwm_generator: table-driven multi-pin PWM
// Cyclic slot table of pin masks with set/clear flags; ticks apply slots,
// edit items write pulses into the table.
// ----------------------------------------------------------------------------
// Usage:
//   item channel (item_valid/item_stall/item) carries one tick or edit per
//   beat; result channel (result_valid/result_stall/result) returns one beat
//   per item with the pin levels and cursor after that item.
//   cfg_wen/cfg_wdata set the slots in use; write only while idle.
// Sequence (from accept to result valid, one item in flight):
//   tick: slot read, apply, result load.
//   add/set pulse: start reduction (one bit per cycle), then
//   the walk over L slots (width or slots in use) at one slot per cycle,
//   then for an add the trailing slot read and write when needed, and
//   the result load. Clear pin / clear all: walk over the slots in use,
//   then the result load. Ignored edits: result load only.
//   The slot memory's single read and single write port set the walk rate.
// Reset: synchronous; afterwards a clearing pass writes every slot with
//   item_stall high (config writes still taken).
// Receiver stall: a result waits in the output register; the next item is
//   accepted and worked on, and holds in its last state until the register
//   frees.
// ----------------------------------------------------------------------------
module pulse_table_pwm_generator #(
  parameter int TABLE_DEPTH = ptpg_pkg::TABLE_DEPTH_DEF,
  parameter int PIN_COUNT   = ptpg_pkg::PIN_COUNT_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        item_valid,
  output logic                        item_stall,
  input  ptpg_pkg::item_t             item,
  output logic                        result_valid,
  input  logic                        result_stall,
  output ptpg_pkg::result_t           result,
  input  logic                        cfg_wen,
  input  logic [ptpg_pkg::CFG_W-1:0]  cfg_wdata
);
  import ptpg_pkg::*;

  cmd_t cmd;
  sts_t sts;

  ptpg_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  ptpg_datapath #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .PIN_COUNT  (PIN_COUNT)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .item        (item),
    .cfg_wen     (cfg_wen),
    .cfg_wdata   (cfg_wdata),
    .cmd         (cmd),
    .sts         (sts),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result      (result)
  );

endmodule
